// ===== src/lphs_pkg.sv =====
// Package for the linear-probing hash set: table geometry, field widths,
// operation, status and sequencer state codes. No dependencies.
`default_nettype none

package lphs_pkg;

  // Table geometry; the slot index is the low bits of the hash
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned SLOT_W   = 4;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(12);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PROBE  = 5'b00010,
    S_RFETCH = 5'b00100,
    S_RPROBE = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== src/linear_probe_hash_set.sv =====
// Linear-probing hash set: slot storage, one shared probe comparator and the
// sequencer that drives it for lookups and for the cluster repair after erase.
// Depends on lphs_pkg.
//
//  Channel  Handshake                 Payload
//  -------  ------------------------  ----------------------------------------
//  cfg      cfg_valid_i / cfg_ready_o  cfg_max_entries_i
//  in       in_valid_i / in_ready_o    mode_i, key_i, key_hash_i
//  out      out_valid_o / out_ready_i  status_o, found_o, slot_o, stored_key_o,
//                                      entry_count_o
//
// One probe step per cycle through a single comparator on one read port.
// Clear goes from idle straight to done; insert and find probe L slots, L the
// probe length (1..16). Erase adds, for each entry of the following cluster,
// a fetch plus that entry's re-probe, and a closing fetch
// on the empty slot after the cluster unless the walk covers all 15 slots.
// Reset clears the valid bits, the entry count and the handshake state;
// max_entries returns to 12. The next transaction is taken while a result
// still waits in the output register; a stalled output holds only the sequencer.
`default_nettype none

module linear_probe_hash_set (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lphs_pkg::CNT_W-1:0]    cfg_max_entries_i,
  // requests
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [lphs_pkg::KEY_W-1:0]    key_i,
  input  wire logic [lphs_pkg::HASH_W-1:0]   key_hash_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic                               found_o,
  output logic [lphs_pkg::SLOT_W-1:0]        slot_o,
  output logic [lphs_pkg::KEY_W-1:0]         stored_key_o,
  output logic [lphs_pkg::CNT_W-1:0]         entry_count_o
);

  localparam int unsigned CAP    = lphs_pkg::CAPACITY;
  localparam int unsigned IDX_W  = lphs_pkg::IDX_W;
  localparam int unsigned KEY_W  = lphs_pkg::KEY_W;
  localparam int unsigned HASH_W = lphs_pkg::HASH_W;
  localparam int unsigned CNT_W  = lphs_pkg::CNT_W;
  localparam int unsigned SLOT_W = lphs_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAP - 1);

  // Slot storage (contents undefined until written)
  logic [HASH_W-1:0] slot_hash_q [CAP];
  logic [KEY_W-1:0]  slot_key_q  [CAP];

  // Control state
  lphs_pkg::state_e  state_q, state_d;
  logic [CAP-1:0]    valid_q, valid_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  max_q, max_d;
  logic              out_valid_q, out_valid_d;

  // Request and working registers
  lphs_pkg::mode_e   req_mode_q, req_mode_d;
  logic [KEY_W-1:0]  req_key_q, req_key_d;
  logic [HASH_W-1:0] req_hash_q, req_hash_d;
  logic [IDX_W-1:0]  p_idx_q, p_idx_d;
  logic [IDX_W-1:0]  p_n_q, p_n_d;
  logic [IDX_W-1:0]  mv_src_q, mv_src_d;
  logic [IDX_W-1:0]  rn_q, rn_d;
  logic [KEY_W-1:0]  mv_key_q, mv_key_d;
  logic [HASH_W-1:0] mv_hash_q, mv_hash_d;

  // Pending result
  lphs_pkg::status_e res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [IDX_W-1:0]  res_slot_q, res_slot_d;
  logic [KEY_W-1:0]  res_skey_q, res_skey_d;

  // Output register
  logic [1:0]        out_status_q;
  logic              out_found_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [KEY_W-1:0]  out_skey_q;
  logic [CNT_W-1:0]  out_count_q;

  // Storage write port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [HASH_W-1:0] wr_hash;
  logic [KEY_W-1:0]  wr_key;

  // Shared read port and probe comparator
  logic [IDX_W-1:0]  rd_idx;
  logic [HASH_W-1:0] rd_hash;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_valid;
  logic [HASH_W-1:0] op_hash;
  logic [KEY_W-1:0]  op_key;
  logic              pr_free, pr_hit, pr_last;
  logic              in_acc, out_load;

  assign in_ready_o  = (state_q == lphs_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == lphs_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  assign rd_idx   = (state_q == lphs_pkg::S_RFETCH) ? mv_src_q : p_idx_q;
  assign rd_hash  = slot_hash_q[rd_idx];
  assign rd_key   = slot_key_q[rd_idx];
  assign rd_valid = valid_q[rd_idx];

  // Operand select: the request, or the entry being re-placed during repair
  assign op_hash = (state_q == lphs_pkg::S_RPROBE) ? mv_hash_q : req_hash_q;
  assign op_key  = (state_q == lphs_pkg::S_RPROBE) ? mv_key_q  : req_key_q;

  assign pr_free = !rd_valid;
  assign pr_hit  = rd_valid && (rd_hash == op_hash) && (rd_key == op_key);
  assign pr_last = (p_n_q == LAST_STEP);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    count_d      = count_q;
    max_d        = max_q;
    req_mode_d   = req_mode_q;
    req_key_d    = req_key_q;
    req_hash_d   = req_hash_q;
    p_idx_d      = p_idx_q;
    p_n_d        = p_n_q;
    mv_src_d     = mv_src_q;
    rn_d         = rn_q;
    mv_key_d     = mv_key_q;
    mv_hash_d    = mv_hash_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_slot_d   = res_slot_q;
    res_skey_d   = res_skey_q;
    wr_en        = 1'b0;
    wr_idx       = p_idx_q;
    wr_hash      = req_hash_q;
    wr_key       = req_key_q;

    if (cfg_valid_i) begin
      max_d = cfg_max_entries_i;
    end

    unique case (state_q)
      lphs_pkg::S_IDLE: begin
        if (in_acc) begin
          req_mode_d   = lphs_pkg::mode_e'(mode_i);
          req_key_d    = key_i;
          req_hash_d   = key_hash_i;
          p_idx_d      = key_hash_i[IDX_W-1:0];
          p_n_d        = '0;
          res_status_d = lphs_pkg::ST_OK;
          res_found_d  = 1'b0;
          res_slot_d   = '0;
          res_skey_d   = '0;
          if (lphs_pkg::mode_e'(mode_i) == lphs_pkg::MODE_CLEAR) begin
            valid_d = '0;
            count_d = '0;
            state_d = lphs_pkg::S_DONE;
          end else begin
            state_d = lphs_pkg::S_PROBE;
          end
        end
      end

      // Request probe: one slot a cycle until hit, free slot or full sweep
      lphs_pkg::S_PROBE: begin
        if (pr_hit) begin
          res_found_d = 1'b1;
          res_slot_d  = p_idx_q;
          state_d     = lphs_pkg::S_DONE;
          case (req_mode_q)
            lphs_pkg::MODE_INSERT: begin
              wr_en = 1'b1;
            end
            lphs_pkg::MODE_FIND: begin
              res_skey_d = rd_key;
            end
            default: begin
              valid_d[p_idx_q] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
              mv_src_d = p_idx_q + IDX_W'(1);
              rn_d     = IDX_W'(1);
              state_d  = lphs_pkg::S_RFETCH;
            end
          endcase
        end else if (pr_free || pr_last) begin
          state_d = lphs_pkg::S_DONE;
          if (req_mode_q == lphs_pkg::MODE_INSERT) begin
            if ((count_q >= max_q) || (count_q >= CNT_W'(CAP)) || !pr_free) begin
              res_status_d = lphs_pkg::ST_FULL;
            end else begin
              wr_en            = 1'b1;
              valid_d[p_idx_q] = 1'b1;
              count_d          = count_q + CNT_W'(1);
              res_slot_d       = p_idx_q;
            end
          end else begin
            res_status_d = lphs_pkg::ST_NOTFOUND;
          end
        end else begin
          p_idx_d = p_idx_q + IDX_W'(1);
          p_n_d   = p_n_q + IDX_W'(1);
        end
      end

      // Repair: pick up the next cluster entry, or stop at an empty slot
      lphs_pkg::S_RFETCH: begin
        if (!rd_valid) begin
          state_d = lphs_pkg::S_DONE;
        end else begin
          mv_key_d  = rd_key;
          mv_hash_d = rd_hash;
          p_idx_d   = rd_hash[IDX_W-1:0];
          p_n_d     = '0;
          state_d   = lphs_pkg::S_RPROBE;
        end
      end

      // Repair: re-probe the entry from its home; move it into an earlier hole
      lphs_pkg::S_RPROBE: begin
        if (pr_hit || pr_free || pr_last) begin
          if (!pr_hit && pr_free && (p_idx_q != mv_src_q)) begin
            wr_en             = 1'b1;
            wr_hash           = mv_hash_q;
            wr_key            = mv_key_q;
            valid_d[p_idx_q]  = 1'b1;
            valid_d[mv_src_q] = 1'b0;
          end
          if (rn_q == LAST_STEP) begin
            state_d = lphs_pkg::S_DONE;
          end else begin
            rn_d     = rn_q + IDX_W'(1);
            mv_src_d = mv_src_q + IDX_W'(1);
            state_d  = lphs_pkg::S_RFETCH;
          end
        end else begin
          p_idx_d = p_idx_q + IDX_W'(1);
          p_n_d   = p_n_q + IDX_W'(1);
        end
      end

      lphs_pkg::S_DONE: begin
        if (out_load) begin
          state_d = lphs_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = lphs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lphs_pkg::S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      max_q       <= lphs_pkg::MAX_ENTRIES_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and pending-result registers
  always_ff @(posedge clk_i) begin
    req_mode_q   <= req_mode_d;
    req_key_q    <= req_key_d;
    req_hash_q   <= req_hash_d;
    p_idx_q      <= p_idx_d;
    p_n_q        <= p_n_d;
    mv_src_q     <= mv_src_d;
    rn_q         <= rn_d;
    mv_key_q     <= mv_key_d;
    mv_hash_q    <= mv_hash_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_slot_q   <= res_slot_d;
    res_skey_q   <= res_skey_d;
  end

  // Slot storage write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_hash_q[wr_idx] <= wr_hash;
      slot_key_q[wr_idx]  <= wr_key;
    end
  end

  // Output register, loaded once all state updates of the transaction are in
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
      out_skey_q   <= res_skey_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign slot_o        = out_slot_q;
  assign stored_key_o  = out_skey_q;
  assign entry_count_o = out_count_q;

endmodule

`default_nettype wire

// ===== src/lphs_checker.sv =====
// Port-level checker for the linear-probing hash set and its bind statement.
// Depends on lphs_pkg and linear_probe_hash_set.
`default_nettype none

module lphs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [1:0]                  status_o,
  input wire logic                        found_o,
  input wire logic [lphs_pkg::SLOT_W-1:0] slot_o,
  input wire logic [lphs_pkg::KEY_W-1:0]  stored_key_o,
  input wire logic [lphs_pkg::CNT_W-1:0]  entry_count_o
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(found_o) && $stable(slot_o) && $stable(stored_key_o) &&
    $stable(entry_count_o))
    else $error("result changed while stalled");

  // A refused insert reports nothing about a slot
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lphs_pkg::ST_FULL) |->
    !found_o && (slot_o == '0) && (stored_key_o == '0))
    else $error("full result carries slot data");

  // A miss reports no hit and slot zero
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lphs_pkg::ST_NOTFOUND) |->
    !found_o && (slot_o == '0) && (stored_key_o == '0))
    else $error("miss result carries slot data");

  // The count never exceeds the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= lphs_pkg::CNT_W'(lphs_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // Found is only reported together with ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (status_o == lphs_pkg::ST_OK))
    else $error("found with error status");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);

`default_nettype wire

// ===== tb/linear_probe_hash_set_tb.sv =====
// Testbench for linear_probe_hash_set: directed and random request streams with
// random idling on both channels, checked by a scoreboard that models the table.
// Depends on lphs_pkg and the linear_probe_hash_set RTL.
module linear_probe_hash_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = lphs_pkg::CAPACITY;
  localparam int unsigned KEY_W    = lphs_pkg::KEY_W;
  localparam int unsigned HASH_W   = lphs_pkg::HASH_W;
  localparam int unsigned CNT_W    = lphs_pkg::CNT_W;
  localparam int unsigned SLOT_W   = lphs_pkg::SLOT_W;

  localparam int unsigned POOL_SIZE   = 20;
  localparam int unsigned SEG_ITEMS   = 200;
  localparam int unsigned NUM_SEGS    = 6;
  localparam int unsigned DRAIN_CYCLES = 300;

  // One expected response
  typedef struct {
    lphs_pkg::status_e  status;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   stored_key;
    logic [CNT_W-1:0]   entry_count;
  } set_response_t;

  // Table model plus queue of responses still owed by the block
  class hash_set_scoreboard;
    bit                 occupied    [CAPACITY];
    logic [KEY_W-1:0]   slot_keys   [CAPACITY];
    logic [HASH_W-1:0]  slot_hashes [CAPACITY];
    int unsigned        live_count;
    int unsigned        max_entries;
    set_response_t      owed_q [$];
    int unsigned        errors;

    function new();
      foreach (occupied[i]) begin
        occupied[i]    = 1'b0;
        slot_keys[i]   = '0;
        slot_hashes[i] = '0;
      end
      live_count  = 0;
      max_entries = int'(lphs_pkg::MAX_ENTRIES_RST);
      errors      = 0;
    endfunction

    // Walk from the home slot to a match or the first empty slot, at most one lap
    function void locate(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
                         output bit hit, output bit free_ok, output int unsigned idx);
      int unsigned pos;
      pos     = hash % CAPACITY;
      hit     = 1'b0;
      free_ok = 1'b0;
      idx     = 0;
      repeat (CAPACITY) begin
        if (!occupied[pos]) begin
          free_ok = 1'b1;
          idx     = pos;
          return;
        end
        if (slot_hashes[pos] == hash && slot_keys[pos] == key) begin
          hit = 1'b1;
          idx = pos;
          return;
        end
        pos = (pos + 1) % CAPACITY;
      end
    endfunction

    // After an erase, pull later cluster members back toward their home slots
    function void close_gap(input int unsigned hole);
      int unsigned pos, dst, n;
      bit hit, free_ok;
      pos = (hole + 1) % CAPACITY;
      for (n = 1; n < CAPACITY && occupied[pos]; n++) begin
        locate(slot_keys[pos], slot_hashes[pos], hit, free_ok, dst);
        if (!hit && free_ok && dst != pos) begin
          slot_keys[dst]   = slot_keys[pos];
          slot_hashes[dst] = slot_hashes[pos];
          occupied[dst]    = 1'b1;
          occupied[pos]    = 1'b0;
        end
        pos = (pos + 1) % CAPACITY;
      end
    endfunction

    // Apply an accepted request to the model and queue its response
    function void note_request(input lphs_pkg::mode_e mode, input logic [KEY_W-1:0] key,
                               input logic [HASH_W-1:0] hash);
      set_response_t rsp;
      bit hit, free_ok;
      int unsigned idx;
      rsp.status     = lphs_pkg::ST_OK;
      rsp.found      = 1'b0;
      rsp.slot       = '0;
      rsp.stored_key = '0;
      if (mode == lphs_pkg::MODE_CLEAR) begin
        foreach (occupied[i]) occupied[i] = 1'b0;
        live_count = 0;
      end else begin
        locate(key, hash, hit, free_ok, idx);
        case (mode)
          lphs_pkg::MODE_INSERT: begin
            if (hit) begin
              rsp.found        = 1'b1;
              rsp.slot         = SLOT_W'(idx);
              slot_keys[idx]   = key;
              slot_hashes[idx] = hash;
            end else if (live_count >= max_entries || live_count >= CAPACITY ||
                         !free_ok) begin
              rsp.status = lphs_pkg::ST_FULL;
            end else begin
              occupied[idx]    = 1'b1;
              slot_keys[idx]   = key;
              slot_hashes[idx] = hash;
              live_count++;
              rsp.slot = SLOT_W'(idx);
            end
          end
          lphs_pkg::MODE_FIND: begin
            if (hit) begin
              rsp.found      = 1'b1;
              rsp.slot       = SLOT_W'(idx);
              rsp.stored_key = slot_keys[idx];
            end else begin
              rsp.status = lphs_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            if (hit) begin
              rsp.found     = 1'b1;
              rsp.slot      = SLOT_W'(idx);
              occupied[idx] = 1'b0;
              if (live_count > 0) live_count--;
              close_gap(idx);
            end else begin
              rsp.status = lphs_pkg::ST_NOTFOUND;
            end
          end
        endcase
      end
      rsp.entry_count = CNT_W'(live_count);
      owed_q.push_back(rsp);
    endfunction

    function void compare_field(input string name, input logic [KEY_W-1:0] want,
                                input logic [KEY_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare an accepted response against the oldest one owed
    function void check_result(input logic [1:0] status, input logic found,
                               input logic [SLOT_W-1:0] slot,
                               input logic [KEY_W-1:0] stored_key,
                               input logic [CNT_W-1:0] entry_count);
      set_response_t rsp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d slot %0d",
                 $time, status, slot);
        errors++;
        return;
      end
      rsp = owed_q.pop_front();
      compare_field("status", KEY_W'(rsp.status), KEY_W'(status));
      compare_field("found", KEY_W'(rsp.found), KEY_W'(found));
      compare_field("slot", KEY_W'(rsp.slot), KEY_W'(slot));
      compare_field("stored_key", rsp.stored_key, stored_key);
      compare_field("entry_count", KEY_W'(rsp.entry_count), KEY_W'(entry_count));
    endfunction
  endclass

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [CNT_W-1:0]   cfg_max_entries_i = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i            = lphs_pkg::MODE_FIND;
  logic [KEY_W-1:0]   key_i             = '0;
  logic [HASH_W-1:0]  key_hash_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic [1:0]         status_o;
  logic               found_o;
  logic [SLOT_W-1:0]  slot_o;
  logic [KEY_W-1:0]   stored_key_o;
  logic [CNT_W-1:0]   entry_count_o;

  hash_set_scoreboard sb;
  int unsigned        send_idle_pct = 15;
  int unsigned        recv_idle_pct = 82;
  logic [KEY_W-1:0]   pool_key  [POOL_SIZE];
  logic [HASH_W-1:0]  pool_hash [POOL_SIZE];

  linear_probe_hash_set dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_max_entries_i (cfg_max_entries_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .key_i             (key_i),
    .key_hash_i        (key_hash_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .found_o           (found_o),
    .slot_o            (slot_o),
    .stored_key_o      (stored_key_o),
    .entry_count_o     (entry_count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // Response side: check each transaction, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(status_o, found_o, slot_o, stored_key_o, entry_count_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Present one request, with a random gap first; valid stays up afterwards
  task automatic send_request(input lphs_pkg::mode_e mode, input logic [KEY_W-1:0] key,
                              input logic [HASH_W-1:0] hash);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    key_i      <= key;
    key_hash_i <= hash;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(mode, key, hash);
  endtask

  task automatic wait_drained();
    while (sb.owed_q.size() != 0) @(posedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_max_entries(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_valid_i       <= 1'b1;
    cfg_max_entries_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    sb.max_entries = int'(value);
  endtask

  // New key population; most hashes crowd around the wrap from slot 15 to 0
  task automatic refill_pool();
    foreach (pool_key[i]) begin
      pool_key[i]  = $urandom();
      pool_hash[i] = $urandom();
      if (i < 12) pool_hash[i][3:0] = 4'((13 + $urandom_range(0, 5)) % 16);
    end
  endtask

  initial begin
    int unsigned  pick, sel, seg, n;
    lphs_pkg::mode_e   mode;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table misses, extreme keys and hashes, wrapping cluster,
    // re-insert of a present key, erase with cluster repair, clear
    send_request(lphs_pkg::MODE_FIND,   32'h0000_0001, 32'h0000_0000);
    send_request(lphs_pkg::MODE_ERASE,  32'h0000_0001, 32'h0000_0000);
    send_request(lphs_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(lphs_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lphs_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lphs_pkg::MODE_INSERT, 32'hA5A5_A5A5, 32'h1234_567F);
    send_request(lphs_pkg::MODE_INSERT, 32'h5A5A_5A5A, 32'h0000_000F);
    send_request(lphs_pkg::MODE_FIND,   32'h5A5A_5A5A, 32'h0000_000F);
    send_request(lphs_pkg::MODE_ERASE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lphs_pkg::MODE_FIND,   32'h5A5A_5A5A, 32'h0000_000F);
    send_request(lphs_pkg::MODE_FIND,   32'hA5A5_A5A5, 32'h1234_567E);
    send_request(lphs_pkg::MODE_CLEAR,  32'h0000_0000, 32'h0000_0000);
    send_request(lphs_pkg::MODE_FIND,   32'h0000_0000, 32'h0000_0000);

    // Directed: smallest limit, refusal of a new key, present key still accepted
    write_max_entries(CNT_W'(1));
    send_request(lphs_pkg::MODE_INSERT, 32'h0000_0011, 32'h0000_0003);
    send_request(lphs_pkg::MODE_INSERT, 32'h0000_0022, 32'h0000_0003);
    send_request(lphs_pkg::MODE_INSERT, 32'h0000_0011, 32'h0000_0003);
    send_request(lphs_pkg::MODE_ERASE,  32'h0000_0011, 32'h0000_0003);

    // Random segments; idling profile changes every two segments
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 82;
        recv_idle_pct = 15;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg % 2 == 0) write_max_entries(CNT_W'(CAPACITY));
      else write_max_entries(CNT_W'($urandom_range(1, CAPACITY)));
      refill_pool();
      for (n = 0; n < SEG_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 2)       mode = lphs_pkg::MODE_CLEAR;
        else if (pick < 50) mode = lphs_pkg::MODE_INSERT;
        else if (pick < 75) mode = lphs_pkg::MODE_FIND;
        else                mode = lphs_pkg::MODE_ERASE;
        sel  = $urandom_range(POOL_SIZE - 1);
        key  = pool_key[sel];
        hash = pool_hash[sel];
        pick = $urandom_range(99);
        // same key and home slot under another hash, or a stray key
        if (pick < 5) begin
          hash = {28'($urandom()), hash[3:0]};
        end else if (pick < 15) begin
          key  = $urandom();
          hash = $urandom();
        end
        send_request(mode, key, hash);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
